// ===== hdl/irpp_pkg.sv =====
// Shared types, constants and saturating helpers for the implicit rotation
// particle pusher. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package irpp_pkg;

  // internal arithmetic width
  localparam int ACC_W = 64;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [2:0][ACC_W-1:0] vec3_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // configuration register indexes
  typedef enum logic {
    CFG_TIME_STEP = 1'b0,
    CFG_CHARGE    = 1'b1
  } cfg_reg_t;

  // value with its clip flag
  typedef struct packed {
    logic ovf;
    acc_t val;
  } sat_t;

  // one particle in flight
  typedef struct packed {
    vec3_t x;
    vec3_t v;
    vec3_t e;
    vec3_t a;
    vec3_t u;
    vec3_t p0;
    vec3_t p1;
    vec3_t p2;
    acc_t  s;
    acc_t  den;
    logic  clip;
  } item_t;

  function automatic sat_t sat_add(input acc_t a, input acc_t b);
    logic [ACC_W:0] sum;
    sat_t res;
    sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    res.ovf = sum[ACC_W] ^ sum[ACC_W-1];
    if (res.ovf) begin
      res.val = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      res.val = sum[ACC_W-1:0];
    end
    return res;
  endfunction

  function automatic sat_t sat_sub(input acc_t a, input acc_t b);
    logic [ACC_W:0] dif;
    sat_t res;
    dif = {a[ACC_W-1], a} - {b[ACC_W-1], b};
    res.ovf = dif[ACC_W] ^ dif[ACC_W-1];
    if (res.ovf) begin
      res.val = dif[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      res.val = dif[ACC_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/irpp_mul.sv =====
// Multi-lane pipelined fixed-point multiplier with round-to-nearest and
// saturation, five register stages; carries a side word along. Uses irpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irpp_mul import irpp_pkg::*; #(
  parameter int LANES     = 1,
  parameter int SIDE_W    = 1,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire acc_t [LANES-1:0]        in_a,
  input  wire acc_t [LANES-1:0]        in_b,
  input  wire logic [SIDE_W-1:0]       side_in,
  output logic                         out_valid,
  output acc_t [LANES-1:0]             out_p,
  output logic                         out_ovf,
  output logic [SIDE_W-1:0]            side_out
);

  localparam int LAT = 5;
  localparam int PW  = 2 * ACC_W;
  localparam int HW  = ACC_W / 2;

  logic [LAT-1:0]             vld_r;
  logic [LAT-1:0][SIDE_W-1:0] side_r;

  logic [LANES-1:0][ACC_W-1:0] ma_r, mb_r, ma_nxt, mb_nxt;
  logic [LANES-1:0]            n1_r, n2_r, n3_r, n4_r, n1_nxt;
  logic [LANES-1:0][ACC_W-1:0] p00_r, p01_r, p10_r, p11_r;
  logic [LANES-1:0][ACC_W-1:0] p00_nxt, p01_nxt, p10_nxt, p11_nxt;
  logic [LANES-1:0][PW-1:0]    prod_r, prod_nxt;
  logic [LANES-1:0][ACC_W-1:0] lo_r, lo_nxt;
  logic [LANES-1:0]            big_r, big_nxt;
  acc_t [LANES-1:0]            res_r, res_nxt;
  logic [LANES-1:0]            ovf_r, ovf_nxt;

  // stage logic, lane by lane
  always_comb begin
    logic [PW-1:0] rnd;
    logic [PW-1:0] q;
    for (int l = 0; l < LANES; l++) begin
      // take magnitudes
      n1_nxt[l] = in_a[l][ACC_W-1] ^ in_b[l][ACC_W-1];
      ma_nxt[l] = in_a[l][ACC_W-1] ? ACC_W'(-in_a[l]) : in_a[l];
      mb_nxt[l] = in_b[l][ACC_W-1] ? ACC_W'(-in_b[l]) : in_b[l];
      // form half-word partial products
      p00_nxt[l] = ma_r[l][HW-1:0] * mb_r[l][HW-1:0];
      p01_nxt[l] = ma_r[l][HW-1:0] * mb_r[l][ACC_W-1:HW];
      p10_nxt[l] = ma_r[l][ACC_W-1:HW] * mb_r[l][HW-1:0];
      p11_nxt[l] = ma_r[l][ACC_W-1:HW] * mb_r[l][ACC_W-1:HW];
      // sum the partials
      prod_nxt[l] = {p11_r[l], p00_r[l]}
                  + {{HW{1'b0}}, p01_r[l], {HW{1'b0}}}
                  + {{HW{1'b0}}, p10_r[l], {HW{1'b0}}};
      // round and drop fraction bits
      rnd = prod_r[l] + (PW'(1) << (FRAC_BITS - 1));
      q   = rnd >> FRAC_BITS;
      lo_nxt[l]  = q[ACC_W-1:0];
      big_nxt[l] = |q[PW-1:ACC_W];
      // apply sign and clip
      if (!n4_r[l]) begin
        ovf_nxt[l] = big_r[l] | lo_r[l][ACC_W-1];
        res_nxt[l] = ovf_nxt[l] ? ACC_MAX : acc_t'(lo_r[l]);
      end else begin
        ovf_nxt[l] = big_r[l] | (lo_r[l][ACC_W-1] & (|lo_r[l][ACC_W-2:0]));
        res_nxt[l] = ovf_nxt[l] ? ACC_MIN : acc_t'(-lo_r[l]);
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    side_r <= {side_r[LAT-2:0], side_in};
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    n1_r   <= n1_nxt;
    n2_r   <= n1_r;
    n3_r   <= n2_r;
    n4_r   <= n3_r;
    p00_r  <= p00_nxt;
    p01_r  <= p01_nxt;
    p10_r  <= p10_nxt;
    p11_r  <= p11_nxt;
    prod_r <= prod_nxt;
    lo_r   <= lo_nxt;
    big_r  <= big_nxt;
    res_r  <= res_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign out_valid = vld_r[LAT-1];
  assign side_out  = side_r[LAT-1];
  assign out_p     = res_r;
  assign out_ovf   = |ovf_r;

endmodule

`default_nettype wire

// ===== hdl/irpp_div.sv =====
// Multi-lane pipelined restoring divider, one quotient bit per stage:
// n * 2^FRAC_BITS / den rounded, for den >= 1.0, saturated. Uses irpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irpp_div import irpp_pkg::*; #(
  parameter int LANES     = 1,
  parameter int SIDE_W    = 1,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire acc_t [LANES-1:0]   in_n,
  input  wire acc_t               in_den,
  input  wire logic [SIDE_W-1:0]  side_in,
  output logic                    out_valid,
  output acc_t [LANES-1:0]        out_q,
  output logic                    out_ovf,
  output logic [SIDE_W-1:0]       side_out
);

  // den >= 1.0 keeps the quotient below 2^ACC_W, so only the low
  // ACC_W+FRAC_BITS dividend bits can produce quotient bits
  localparam int NW    = ACC_W + FRAC_BITS;
  localparam int STEPS = NW;
  localparam int LAT   = STEPS + 3;

  logic [LAT-1:0]             vld_r;
  logic [LAT-1:0][SIDE_W-1:0] side_r;

  logic [LANES-1:0][ACC_W-1:0] mag_r, mag_nxt;
  logic [LANES-1:0]            ngm_r, ngm_nxt;
  logic [ACC_W-1:0]            dm_r;

  logic [STEPS:0][LANES-1:0][ACC_W-1:0] rem_r, rem_nxt;
  logic [STEPS:0][LANES-1:0][ACC_W-1:0] q_r, q_nxt;
  logic [STEPS:0][LANES-1:0][NW-1:0]    nb_r, nb_nxt;
  logic [STEPS:0][LANES-1:0]            ng_r, ng_nxt;
  logic [STEPS:0][ACC_W-1:0]            dv_r, dv_nxt;

  acc_t [LANES-1:0] res_r, res_nxt;
  logic [LANES-1:0] ovf_r, ovf_nxt;

  always_comb begin
    logic [ACC_W:0] rsh;
    logic           ge;
    // take magnitudes
    for (int l = 0; l < LANES; l++) begin
      ngm_nxt[l] = in_n[l][ACC_W-1];
      mag_nxt[l] = in_n[l][ACC_W-1] ? ACC_W'(-in_n[l]) : in_n[l];
    end
    // scale dividend and add half the divisor
    dv_nxt[0] = dm_r;
    for (int l = 0; l < LANES; l++) begin
      rem_nxt[0][l] = '0;
      q_nxt[0][l]   = '0;
      ng_nxt[0][l]  = ngm_r[l];
      nb_nxt[0][l]  = {mag_r[l], {FRAC_BITS{1'b0}}} + NW'(dm_r >> 1);
    end
    // one quotient bit per stage
    for (int s = 0; s < STEPS; s++) begin
      dv_nxt[s+1] = dv_r[s];
      for (int l = 0; l < LANES; l++) begin
        rsh = {rem_r[s][l], nb_r[s][l][NW-1]};
        ge  = rsh >= {1'b0, dv_r[s]};
        rem_nxt[s+1][l] = ge ? ACC_W'(rsh - {1'b0, dv_r[s]}) : rsh[ACC_W-1:0];
        q_nxt[s+1][l]   = {q_r[s][l][ACC_W-2:0], ge};
        nb_nxt[s+1][l]  = nb_r[s][l] << 1;
        ng_nxt[s+1][l]  = ng_r[s][l];
      end
    end
    // apply sign and clip
    for (int l = 0; l < LANES; l++) begin
      if (!ng_r[STEPS][l]) begin
        ovf_nxt[l] = q_r[STEPS][l][ACC_W-1];
        res_nxt[l] = ovf_nxt[l] ? ACC_MAX : acc_t'(q_r[STEPS][l]);
      end else begin
        ovf_nxt[l] = q_r[STEPS][l][ACC_W-1] & (|q_r[STEPS][l][ACC_W-2:0]);
        res_nxt[l] = ovf_nxt[l] ? ACC_MIN : acc_t'(-q_r[STEPS][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    side_r <= {side_r[LAT-2:0], side_in};
    mag_r  <= mag_nxt;
    ngm_r  <= ngm_nxt;
    dm_r   <= in_den;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    nb_r   <= nb_nxt;
    ng_r   <= ng_nxt;
    dv_r   <= dv_nxt;
    res_r  <= res_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign out_valid = vld_r[LAT-1];
  assign side_out  = side_r[LAT-1];
  assign out_q     = res_r;
  assign out_ovf   = |ovf_r;

endmodule

`default_nettype wire

// ===== hdl/implicit_rotation_particle_push.sv =====
// Top level of the implicit rotation particle pusher: config registers and
// the arithmetic pipeline. Depends on irpp_pkg, irpp_mul and irpp_div.
`timescale 1ns / 1ps
`default_nettype none

// One particle enters per clock while busy is low; its word leaves flagged
// by out_strobe for exactly one cycle; the receiver cannot stall, so results
// must be taken as they appear. The data path holds five five-stage
// multiplier passes, seven saturating add stages, the output register and
// the divider, which resolves one of its 64 + FRAC_BITS quotient bits per
// stage plus three stages to scale, sign and clip. busy is high during reset
// and after reset or after any configuration write until the charge-times-
// step product has settled through its multiplier; a particle offered then waits.

module implicit_rotation_particle_push import irpp_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] in_pos_x,
  input  wire logic signed [DATA_WIDTH-1:0] in_pos_y,
  input  wire logic signed [DATA_WIDTH-1:0] in_pos_z,
  input  wire logic signed [DATA_WIDTH-1:0] in_vel_x,
  input  wire logic signed [DATA_WIDTH-1:0] in_vel_y,
  input  wire logic signed [DATA_WIDTH-1:0] in_vel_z,
  input  wire logic signed [DATA_WIDTH-1:0] in_efield_x,
  input  wire logic signed [DATA_WIDTH-1:0] in_efield_y,
  input  wire logic signed [DATA_WIDTH-1:0] in_efield_z,
  input  wire logic signed [DATA_WIDTH-1:0] in_bfield_x,
  input  wire logic signed [DATA_WIDTH-1:0] in_bfield_y,
  input  wire logic signed [DATA_WIDTH-1:0] in_bfield_z,
  output logic                              out_strobe,
  output logic signed [DATA_WIDTH-1:0]      out_new_pos_x,
  output logic signed [DATA_WIDTH-1:0]      out_new_pos_y,
  output logic signed [DATA_WIDTH-1:0]      out_new_pos_z,
  output logic signed [DATA_WIDTH-1:0]      out_new_vel_x,
  output logic signed [DATA_WIDTH-1:0]      out_new_vel_y,
  output logic signed [DATA_WIDTH-1:0]      out_new_vel_z,
  output logic                              out_saturated,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_index,
  input  wire logic [DATA_WIDTH-1:0]        cfg_data
);

  localparam int   IW     = $bits(item_t);
  localparam int   TW     = DATA_WIDTH - 1;
  localparam acc_t ONE    = acc_t'(ACC_W'(1) << FRAC_BITS);
  localparam acc_t OUT_HI = acc_t'((ACC_W'(1) << (DATA_WIDTH - 1)) - ACC_W'(1));
  localparam acc_t OUT_LO = acc_t'(-OUT_HI - acc_t'(1));
  // cycles for a new k to reach the multiplier output
  localparam logic [2:0] K_SETTLE = 3'd5;

  logic                         busy_r;
  logic [2:0]                   settle_r;
  logic [TW-1:0]                ts_r;
  logic signed [DATA_WIDTH-1:0] qm_r;

  // hold reset status and configuration, wait for k to settle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      settle_r <= K_SETTLE;
      ts_r     <= '0;
      qm_r     <= '0;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        settle_r <= K_SETTLE;
        unique case (cfg_reg_t'(cfg_index))
          CFG_TIME_STEP: ts_r <= cfg_data[TW-1:0];
          CFG_CHARGE:    qm_r <= cfg_data;
        endcase
      end else if (settle_r != '0) begin
        settle_r <= settle_r - 3'd1;
      end
    end
  end

  assign busy      = busy_r | (settle_r != '0);
  assign cfg_ready = ~busy_r;

  // k = charge_to_mass * time_step, step length rides alongside
  acc_t [0:0] k_a, k_b, k_p;
  logic       k_vld, k_ovf;
  logic [TW-1:0] dt_k;

  assign k_a[0] = ACC_W'(qm_r);
  assign k_b[0] = acc_t'(ACC_W'(ts_r));

  irpp_mul #(.LANES(1), .SIDE_W(TW), .FRAC_BITS(FRAC_BITS)) u_kmul (
    .clk(clk), .rst_n(rst_n), .in_valid(1'b1),
    .in_a(k_a), .in_b(k_b), .side_in(ts_r),
    .out_valid(k_vld), .out_p(k_p), .out_ovf(k_ovf), .side_out(dt_k)
  );

  // build the entering word
  item_t it0;
  logic  acc_in;
  always_comb begin
    it0 = '0;
    it0.x[0] = ACC_W'(in_pos_x);
    it0.x[1] = ACC_W'(in_pos_y);
    it0.x[2] = ACC_W'(in_pos_z);
    it0.v[0] = ACC_W'(in_vel_x);
    it0.v[1] = ACC_W'(in_vel_y);
    it0.v[2] = ACC_W'(in_vel_z);
    it0.e[0] = ACC_W'(in_efield_x);
    it0.e[1] = ACC_W'(in_efield_y);
    it0.e[2] = ACC_W'(in_efield_z);
    it0.a[0] = ACC_W'(in_bfield_x);
    it0.a[1] = ACC_W'(in_bfield_y);
    it0.a[2] = ACC_W'(in_bfield_z);
    it0.clip = k_ovf & k_vld;
  end
  assign acc_in = start & ~busy;

  // pass 1: scale fields by k
  acc_t [5:0] m1_a, m1_b, m1_p;
  logic [IW-1:0] m1_side;
  logic m1_vld, m1_ovf;
  item_t it1;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m1_a[i]   = k_p[0];
      m1_b[i]   = it0.e[i];
      m1_a[3+i] = k_p[0];
      m1_b[3+i] = it0.a[i];
    end
  end
  irpp_mul #(.LANES(6), .SIDE_W(IW), .FRAC_BITS(FRAC_BITS)) u_mul1 (
    .clk(clk), .rst_n(rst_n), .in_valid(acc_in),
    .in_a(m1_a), .in_b(m1_b), .side_in(it0),
    .out_valid(m1_vld), .out_p(m1_p), .out_ovf(m1_ovf), .side_out(m1_side)
  );
  always_comb begin
    it1 = item_t'(m1_side);
    for (int i = 0; i < 3; i++) begin
      it1.e[i] = m1_p[i];
      it1.a[i] = m1_p[3+i];
    end
    it1.clip = it1.clip | m1_ovf;
  end

  // pass 2: v x a terms and squares of a
  acc_t [8:0] m2_a, m2_b, m2_p;
  logic [IW-1:0] m2_side;
  logic m2_vld, m2_ovf;
  item_t it2;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m2_a[i]   = it1.v[(i+1)%3];
      m2_b[i]   = it1.a[(i+2)%3];
      m2_a[3+i] = it1.v[(i+2)%3];
      m2_b[3+i] = it1.a[(i+1)%3];
      m2_a[6+i] = it1.a[i];
      m2_b[6+i] = it1.a[i];
    end
  end
  irpp_mul #(.LANES(9), .SIDE_W(IW), .FRAC_BITS(FRAC_BITS)) u_mul2 (
    .clk(clk), .rst_n(rst_n), .in_valid(m1_vld),
    .in_a(m2_a), .in_b(m2_b), .side_in(it1),
    .out_valid(m2_vld), .out_p(m2_p), .out_ovf(m2_ovf), .side_out(m2_side)
  );
  always_comb begin
    it2 = item_t'(m2_side);
    for (int i = 0; i < 3; i++) begin
      it2.p0[i] = m2_p[i];
      it2.p1[i] = m2_p[3+i];
      it2.p2[i] = m2_p[6+i];
    end
    it2.clip = it2.clip | m2_ovf;
  end

  // add stages 1..3: cross product, u, denominator
  item_t r1_r, r1_nxt, r2_r, r2_nxt, r3_r, r3_nxt;
  logic  r1_v_r, r2_v_r, r3_v_r;
  always_comb begin
    sat_t t;
    sat_t w;
    r1_nxt = it2;
    for (int i = 0; i < 3; i++) begin
      t = sat_sub(it2.p0[i], it2.p1[i]);
      r1_nxt.p0[i] = t.val;
      r1_nxt.clip  = r1_nxt.clip | t.ovf;
    end
    t = sat_add(it2.p2[0], it2.p2[1]);
    r1_nxt.s    = t.val;
    r1_nxt.clip = r1_nxt.clip | t.ovf;

    r2_nxt = r1_r;
    for (int i = 0; i < 3; i++) begin
      t = sat_add(r1_r.v[i], r1_r.p0[i]);
      r2_nxt.u[i] = t.val;
      r2_nxt.clip = r2_nxt.clip | t.ovf;
    end
    t = sat_add(r1_r.s, r1_r.p2[2]);
    r2_nxt.s    = t.val;
    r2_nxt.clip = r2_nxt.clip | t.ovf;

    r3_nxt = r2_r;
    for (int i = 0; i < 3; i++) begin
      t = sat_add(r2_r.u[i], r2_r.e[i]);
      r3_nxt.u[i] = t.val;
      r3_nxt.clip = r3_nxt.clip | t.ovf;
    end
    w = sat_add(ONE, r2_r.s);
    r3_nxt.den  = ($signed(w.val) < $signed(ONE)) ? ONE : w.val;
    r3_nxt.clip = r3_nxt.clip | w.ovf;
  end

  // pass 3: a x u terms and a.u terms
  acc_t [8:0] m3_a, m3_b, m3_p;
  logic [IW-1:0] m3_side;
  logic m3_vld, m3_ovf;
  item_t it3;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m3_a[i]   = r3_r.a[(i+1)%3];
      m3_b[i]   = r3_r.u[(i+2)%3];
      m3_a[3+i] = r3_r.a[(i+2)%3];
      m3_b[3+i] = r3_r.u[(i+1)%3];
      m3_a[6+i] = r3_r.a[i];
      m3_b[6+i] = r3_r.u[i];
    end
  end
  irpp_mul #(.LANES(9), .SIDE_W(IW), .FRAC_BITS(FRAC_BITS)) u_mul3 (
    .clk(clk), .rst_n(rst_n), .in_valid(r3_v_r),
    .in_a(m3_a), .in_b(m3_b), .side_in(r3_r),
    .out_valid(m3_vld), .out_p(m3_p), .out_ovf(m3_ovf), .side_out(m3_side)
  );
  always_comb begin
    it3 = item_t'(m3_side);
    for (int i = 0; i < 3; i++) begin
      it3.p0[i] = m3_p[i];
      it3.p1[i] = m3_p[3+i];
      it3.p2[i] = m3_p[6+i];
    end
    it3.clip = it3.clip | m3_ovf;
  end

  // add stages 4..5: d = a x u, s = a.u, u - d
  item_t r4_r, r4_nxt, r5_r, r5_nxt;
  logic  r4_v_r, r5_v_r;
  always_comb begin
    sat_t t;
    r4_nxt = it3;
    for (int i = 0; i < 3; i++) begin
      t = sat_sub(it3.p0[i], it3.p1[i]);
      r4_nxt.p0[i] = t.val;
      r4_nxt.clip  = r4_nxt.clip | t.ovf;
    end
    t = sat_add(it3.p2[0], it3.p2[1]);
    r4_nxt.s    = t.val;
    r4_nxt.clip = r4_nxt.clip | t.ovf;

    r5_nxt = r4_r;
    for (int i = 0; i < 3; i++) begin
      t = sat_sub(r4_r.u[i], r4_r.p0[i]);
      r5_nxt.p0[i] = t.val;
      r5_nxt.clip  = r5_nxt.clip | t.ovf;
    end
    t = sat_add(r4_r.s, r4_r.p2[2]);
    r5_nxt.s    = t.val;
    r5_nxt.clip = r5_nxt.clip | t.ovf;
  end

  // pass 4: a * s
  acc_t [2:0] m4_a, m4_b, m4_p;
  logic [IW-1:0] m4_side;
  logic m4_vld, m4_ovf;
  item_t it4;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m4_a[i] = r5_r.a[i];
      m4_b[i] = r5_r.s;
    end
  end
  irpp_mul #(.LANES(3), .SIDE_W(IW), .FRAC_BITS(FRAC_BITS)) u_mul4 (
    .clk(clk), .rst_n(rst_n), .in_valid(r5_v_r),
    .in_a(m4_a), .in_b(m4_b), .side_in(r5_r),
    .out_valid(m4_vld), .out_p(m4_p), .out_ovf(m4_ovf), .side_out(m4_side)
  );
  always_comb begin
    it4 = item_t'(m4_side);
    for (int i = 0; i < 3; i++) begin
      it4.p1[i] = m4_p[i];
    end
    it4.clip = it4.clip | m4_ovf;
  end

  // add stage 6: numerator
  item_t r6_r, r6_nxt;
  logic  r6_v_r;
  always_comb begin
    sat_t t;
    r6_nxt = it4;
    for (int i = 0; i < 3; i++) begin
      t = sat_add(it4.p0[i], it4.p1[i]);
      r6_nxt.p0[i] = t.val;
      r6_nxt.clip  = r6_nxt.clip | t.ovf;
    end
  end

  // divide by the determinant
  acc_t [2:0] dv_n, dv_q;
  logic [IW-1:0] dv_side;
  logic dv_vld, dv_ovf;
  item_t it5;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_n[i] = r6_r.p0[i];
    end
  end
  irpp_div #(.LANES(3), .SIDE_W(IW), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .in_valid(r6_v_r),
    .in_n(dv_n), .in_den(r6_r.den), .side_in(r6_r),
    .out_valid(dv_vld), .out_q(dv_q), .out_ovf(dv_ovf), .side_out(dv_side)
  );
  always_comb begin
    it5 = item_t'(dv_side);
    for (int i = 0; i < 3; i++) begin
      it5.v[i] = dv_q[i];
    end
    it5.clip = it5.clip | dv_ovf;
  end

  // pass 5: dt * v'
  acc_t [2:0] m5_a, m5_b, m5_p;
  logic [IW-1:0] m5_side;
  logic m5_vld, m5_ovf;
  item_t it6;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m5_a[i] = acc_t'(ACC_W'(dt_k));
      m5_b[i] = it5.v[i];
    end
  end
  irpp_mul #(.LANES(3), .SIDE_W(IW), .FRAC_BITS(FRAC_BITS)) u_mul5 (
    .clk(clk), .rst_n(rst_n), .in_valid(dv_vld),
    .in_a(m5_a), .in_b(m5_b), .side_in(it5),
    .out_valid(m5_vld), .out_p(m5_p), .out_ovf(m5_ovf), .side_out(m5_side)
  );
  always_comb begin
    it6 = item_t'(m5_side);
    for (int i = 0; i < 3; i++) begin
      it6.p0[i] = m5_p[i];
    end
    it6.clip = it6.clip | m5_ovf;
  end

  // add stage 7: new position
  item_t r7_r, r7_nxt;
  logic  r7_v_r;
  always_comb begin
    sat_t t;
    r7_nxt = it6;
    for (int i = 0; i < 3; i++) begin
      t = sat_add(it6.x[i], it6.p0[i]);
      r7_nxt.x[i] = t.val;
      r7_nxt.clip = r7_nxt.clip | t.ovf;
    end
  end

  // output stage: clip to port width
  logic [2:0][DATA_WIDTH-1:0] px_r, px_nxt, pv_r, pv_nxt;
  logic                       sat_r, sat_nxt, strobe_r;
  always_comb begin
    sat_nxt = r7_r.clip;
    for (int i = 0; i < 3; i++) begin
      if ($signed(r7_r.x[i]) > OUT_HI) begin
        px_nxt[i] = OUT_HI[DATA_WIDTH-1:0];
        sat_nxt   = 1'b1;
      end else if ($signed(r7_r.x[i]) < OUT_LO) begin
        px_nxt[i] = OUT_LO[DATA_WIDTH-1:0];
        sat_nxt   = 1'b1;
      end else begin
        px_nxt[i] = r7_r.x[i][DATA_WIDTH-1:0];
      end
      if ($signed(r7_r.v[i]) > OUT_HI) begin
        pv_nxt[i] = OUT_HI[DATA_WIDTH-1:0];
        sat_nxt   = 1'b1;
      end else if ($signed(r7_r.v[i]) < OUT_LO) begin
        pv_nxt[i] = OUT_LO[DATA_WIDTH-1:0];
        sat_nxt   = 1'b1;
      end else begin
        pv_nxt[i] = r7_r.v[i][DATA_WIDTH-1:0];
      end
    end
  end

  // valid bits of the add stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r   <= 1'b0;
      r2_v_r   <= 1'b0;
      r3_v_r   <= 1'b0;
      r4_v_r   <= 1'b0;
      r5_v_r   <= 1'b0;
      r6_v_r   <= 1'b0;
      r7_v_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      r1_v_r   <= m2_vld;
      r2_v_r   <= r1_v_r;
      r3_v_r   <= r2_v_r;
      r4_v_r   <= m3_vld;
      r5_v_r   <= r4_v_r;
      r6_v_r   <= m4_vld;
      r7_v_r   <= m5_vld;
      strobe_r <= r7_v_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    r1_r  <= r1_nxt;
    r2_r  <= r2_nxt;
    r3_r  <= r3_nxt;
    r4_r  <= r4_nxt;
    r5_r  <= r5_nxt;
    r6_r  <= r6_nxt;
    r7_r  <= r7_nxt;
    px_r  <= px_nxt;
    pv_r  <= pv_nxt;
    sat_r <= sat_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_new_pos_x = px_r[0];
  assign out_new_pos_y = px_r[1];
  assign out_new_pos_z = px_r[2];
  assign out_new_vel_x = pv_r[0];
  assign out_new_vel_y = pv_r[1];
  assign out_new_vel_z = pv_r[2];
  assign out_saturated = sat_r;

endmodule

`default_nettype wire

// ===== tb/sv/irpp_checker.sv =====
// Scoreboard for the implicit rotation particle pusher: tracks config writes,
// predicts each pushed particle and compares every output word. Needs irpp_pkg.
`timescale 1ns / 1ps

module irpp_checker import irpp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [31:0] in_vel_x,
  input  wire logic signed [31:0] in_vel_y,
  input  wire logic signed [31:0] in_vel_z,
  input  wire logic signed [31:0] in_efield_x,
  input  wire logic signed [31:0] in_efield_y,
  input  wire logic signed [31:0] in_efield_z,
  input  wire logic signed [31:0] in_bfield_x,
  input  wire logic signed [31:0] in_bfield_y,
  input  wire logic signed [31:0] in_bfield_z,
  input  wire logic               out_strobe,
  input  wire logic signed [31:0] out_new_pos_x,
  input  wire logic signed [31:0] out_new_pos_y,
  input  wire logic signed [31:0] out_new_pos_z,
  input  wire logic signed [31:0] out_new_vel_x,
  input  wire logic signed [31:0] out_new_vel_y,
  input  wire logic signed [31:0] out_new_vel_z,
  input  wire logic               out_saturated,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data,
  output int                      fail_count,
  output int                      pending,
  output int                      words_seen,
  output int                      clipped_words
);

  localparam int FB = 16;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
    logic               sat;
  } push_word_t;

  push_word_t         expected_pushes [$];
  logic        [30:0] step_len;
  logic signed [31:0] q_over_m;
  logic               clip_hit;

  // 64-bit saturation from a magnitude and sign
  function automatic acc_t clamp_mag(input logic neg, input logic [128:0] m);
    if (!neg) begin
      if (m > 129'h7FFF_FFFF_FFFF_FFFF) begin
        clip_hit = 1'b1;
        return ACC_MAX;
      end
      return m[63:0];
    end
    if (m > 129'h8000_0000_0000_0000) begin
      clip_hit = 1'b1;
      return ACC_MIN;
    end
    return -m[63:0];
  endfunction

  // fixed-point product, rounded half away from zero
  function automatic acc_t fx_mul(input acc_t x, input acc_t y);
    logic [63:0]  am, bm;
    logic [128:0] p;
    am = x[63] ? -x : x;
    bm = y[63] ? -y : y;
    p = {65'd0, am} * {65'd0, bm};
    p = (p + 129'd32768) >> FB;
    return clamp_mag(x[63] ^ y[63], p);
  endfunction

  // fixed-point quotient by a positive denominator
  function automatic acc_t fx_div(input acc_t n, input acc_t den);
    logic [63:0]  am;
    logic [128:0] num;
    am = n[63] ? -n : n;
    num = ({65'd0, am} << FB) + {65'd0, den >> 1};
    num = num / {65'd0, den};
    return clamp_mag(n[63], num);
  endfunction

  function automatic acc_t s_add(input acc_t a, input acc_t b);
    sat_t r;
    r = sat_add(a, b);
    if (r.ovf) clip_hit = 1'b1;
    return r.val;
  endfunction

  function automatic acc_t s_sub(input acc_t a, input acc_t b);
    sat_t r;
    r = sat_sub(a, b);
    if (r.ovf) clip_hit = 1'b1;
    return r.val;
  endfunction

  function automatic logic signed [31:0] clip32(input acc_t v);
    if (v > 64'sh7FFF_FFFF) begin
      clip_hit = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      clip_hit = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // one Boris step for the particle sampled at the push
  function automatic push_word_t boris_step(input logic signed [31:0] f [12]);
    push_word_t w;
    acc_t x [3], v [3], e [3], a [3], u [3], vn [3];
    acc_t c, d, nn, dt, k, s, den;
    int j, m;
    clip_hit = 1'b0;
    dt = {33'd0, step_len};
    k = fx_mul({{32{q_over_m[31]}}, q_over_m}, dt);
    for (int i = 0; i < 3; i++) begin
      x[i] = f[i];
      v[i] = f[3+i];
      e[i] = fx_mul(k, acc_t'(f[6+i]));
      a[i] = fx_mul(k, acc_t'(f[9+i]));
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      m = (i + 2) % 3;
      c = s_sub(fx_mul(v[j], a[m]), fx_mul(v[m], a[j]));
      u[i] = s_add(s_add(v[i], c), e[i]);
    end
    s = s_add(s_add(fx_mul(a[0], u[0]), fx_mul(a[1], u[1])), fx_mul(a[2], u[2]));
    den = s_add(64'sd65536, s_add(s_add(fx_mul(a[0], a[0]), fx_mul(a[1], a[1])),
                                  fx_mul(a[2], a[2])));
    if (den < 64'sd65536) den = 64'sd65536;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      m = (i + 2) % 3;
      d = s_sub(fx_mul(a[j], u[m]), fx_mul(a[m], u[j]));
      nn = s_add(s_sub(u[i], d), fx_mul(a[i], s));
      vn[i] = fx_div(nn, den);
    end
    for (int i = 0; i < 3; i++) begin
      w.pos[i] = clip32(s_add(x[i], fx_mul(dt, vn[i])));
      w.vel[i] = clip32(vn[i]);
    end
    w.sat = clip_hit;
    return w;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %h, want %h", $time, field, got, want);
    fail_count++;
  endtask

  assign pending = expected_pushes.size();

  initial begin
    fail_count = 0;
    words_seen = 0;
    clipped_words = 0;
  end

  // track registers, predict on push, compare on strobe
  always @(posedge clk) begin
    logic signed [31:0] f [12];
    push_word_t w;
    if (!rst_n) begin
      step_len <= '0;
      q_over_m <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TIME_STEP) step_len <= cfg_data[30:0];
        else q_over_m <= cfg_data;
      end
      if (start && !busy) begin
        f = '{in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z,
              in_efield_x, in_efield_y, in_efield_z,
              in_bfield_x, in_bfield_y, in_bfield_z};
        expected_pushes.push_back(boris_step(f));
      end
      if (out_strobe) begin
        words_seen++;
        if (expected_pushes.size() == 0) begin
          $display("[%0t] MISMATCH unexpected output word", $time);
          fail_count++;
        end else begin
          w = expected_pushes.pop_front();
          if (w.sat) clipped_words++;
          if (out_new_pos_x !== w.pos[0]) report_mismatch("new_pos_x", out_new_pos_x, w.pos[0]);
          if (out_new_pos_y !== w.pos[1]) report_mismatch("new_pos_y", out_new_pos_y, w.pos[1]);
          if (out_new_pos_z !== w.pos[2]) report_mismatch("new_pos_z", out_new_pos_z, w.pos[2]);
          if (out_new_vel_x !== w.vel[0]) report_mismatch("new_vel_x", out_new_vel_x, w.vel[0]);
          if (out_new_vel_y !== w.vel[1]) report_mismatch("new_vel_y", out_new_vel_y, w.vel[1]);
          if (out_new_vel_z !== w.vel[2]) report_mismatch("new_vel_z", out_new_vel_z, w.vel[2]);
          if (out_saturated !== w.sat) report_mismatch("saturated", out_saturated, w.sat);
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Stimulus and verdict for the implicit rotation particle pusher bench.
// Depends on irpp_pkg, the block RTL and irpp_checker.
`timescale 1ns / 1ps

module tb_top import irpp_pkg::*;;

  localparam int STALL_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic signed [31:0] in_efield_x = '0, in_efield_y = '0, in_efield_z = '0;
  logic signed [31:0] in_bfield_x = '0, in_bfield_y = '0, in_bfield_z = '0;
  logic               out_strobe;
  logic signed [31:0] out_new_pos_x, out_new_pos_y, out_new_pos_z;
  logic signed [31:0] out_new_vel_x, out_new_vel_y, out_new_vel_z;
  logic               out_saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_TIME_STEP;
  logic        [31:0] cfg_data = '0;
  int                 fail_count, pending, words_seen, clipped_words;
  int                 pushed = 0;
  int                 quiet_cycles = 0;
  bit                 calm = 1'b0;

  always #5 clk = ~clk;

  implicit_rotation_particle_push u_top (.*);
  irpp_checker u_chk (.*);

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // write one register once the pipeline has drained
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    repeat (6) @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] dt, input logic [31:0] qm);
    write_reg(CFG_TIME_STEP, dt);
    write_reg(CFG_CHARGE, qm);
  endtask

  // push one particle, then at random idle with start low
  task automatic push_particle(input logic signed [31:0] f [12]);
    {in_pos_x, in_pos_y, in_pos_z} <= {f[0], f[1], f[2]};
    {in_vel_x, in_vel_y, in_vel_z} <= {f[3], f[4], f[5]};
    {in_efield_x, in_efield_y, in_efield_z} <= {f[6], f[7], f[8]};
    {in_bfield_x, in_bfield_y, in_bfield_z} <= {f[9], f[10], f[11]};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pushed++;
    if (!calm && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_field();
    case ($urandom_range(0, 9))
      8:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      9:       return '0;
      6, 7:    return $urandom;
      default: return $signed($urandom) >>> $urandom_range(6, 20);
    endcase
  endfunction

  function automatic logic [31:0] rand_charge();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom) >>> $urandom_range(12, 22);
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0;
      default: return $urandom_range(0, 32'h0002_0000);
    endcase
  endfunction

  initial begin
    logic signed [31:0] f [12];
    logic [31:0] step_set [4];
    logic [31:0] q_set [4];
    step_set = '{32'h0, 32'h7FFF_FFFF, 32'h0000_1000, 32'h0001_0000};
    q_set = '{32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: register extremes against field extremes and a gyrating case
    for (int p = 0; p < 4; p++) begin
      set_regs(step_set[p], q_set[p]);
      foreach (f[i]) f[i] = '0;
      push_particle(f);
      foreach (f[i]) f[i] = 32'sh7FFF_FFFF;
      push_particle(f);
      foreach (f[i]) f[i] = 32'sh8000_0000;
      push_particle(f);
      f = '{32'sh0001_0000, -32'sh0002_0000, 32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0,
            32'sh0, 32'sh0000_8000, 32'sh0, 32'sh0, 32'sh0, 32'sh0002_0000};
      push_particle(f);
      foreach (f[i]) f[i] = (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      push_particle(f);
    end

    // random: fresh register settings per phase, one quiet stretch
    for (int p = 0; p < 12; p++) begin
      set_regs(rand_step(), rand_charge());
      for (int n = 0; n < 36; n++) begin
        calm = (pushed >= 180 && pushed < 260);
        foreach (f[i]) f[i] = rand_field();
        push_particle(f);
      end
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    $display("Pushed %0d particles over 16 register settings; %0d words checked, %0d clipped.",
             pushed, words_seen, clipped_words);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/irpp_pkg.sv
hdl/irpp_mul.sv
hdl/irpp_div.sv
hdl/implicit_rotation_particle_push.sv
tb/sv/irpp_checker.sv
tb/sv/tb_top.sv
